>>> rtl/open_address_hash_table_assert.svh
// Assertion macros shared by the checker.
`ifndef OPEN_ADDRESS_HASH_TABLE_ASSERT_SVH
`define OPEN_ADDRESS_HASH_TABLE_ASSERT_SVH

// Asserts that a condition implies another one in the same cycle.
`define OAHT_ASSERT_IMP(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("assertion failed");

// Asserts that a condition implies another one in the next cycle.
`define OAHT_ASSERT_NEXT(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("assertion failed");

`endif

>>> rtl/oaht_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package oaht_pkg;

    typedef enum logic [1:0] {
        MODE_GET = 2'd0,
        MODE_PUT = 2'd1,
        MODE_DEL = 2'd2,
        MODE_NOP = 2'd3
    } t_mode;

    typedef struct packed {
        logic [1:0]  mode;
        logic [31:0] key;
        logic [31:0] value;
    } t_in_item;

    typedef struct packed {
        logic        ok;
        logic [31:0] read_value;
        logic [10:0] live_count;
    } t_out_item;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CLEAR,
        ST_READ,
        ST_WAIT,
        ST_CHECK,
        ST_DONE
    } t_state;

endpackage
`default_nettype wire

>>> rtl/oaht_front.sv
`timescale 1ns / 1ps
`default_nettype none
// Input queue: two entries between the port and the probe engine.
module oaht_front (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_valid,
    output logic                o_stall,
    input  oaht_pkg::t_in_item  i_data,
    output logic                o_valid,
    input  wire                 i_take,
    output oaht_pkg::t_in_item  o_data
);
    oaht_pkg::t_in_item r_q [2];
    logic [1:0] r_cnt, n_cnt;
    logic       r_rd, r_wr;
    logic       push, pop;

    assign o_stall = (r_cnt == 2'd2);
    assign push    = i_valid && !o_stall;
    assign o_valid = (r_cnt != 2'd0);
    assign pop     = o_valid && i_take;
    assign o_data  = r_q[r_rd];

    always_comb begin
        n_cnt = r_cnt + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
            r_rd  <= 1'b0;
            r_wr  <= 1'b0;
        end else begin
            r_cnt <= n_cnt;
            if (push) r_wr <= !r_wr;
            if (pop)  r_rd <= !r_rd;
        end
        if (push) r_q[r_wr] <= i_data;
    end
endmodule
`default_nettype wire

>>> rtl/oaht_back.sv
`timescale 1ns / 1ps
`default_nettype none
module oaht_back #(
    parameter int SLOTS      = 1024,
    parameter int KEY_BITS   = 32,
    parameter int VALUE_BITS = 32
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_valid,
    output logic                o_take,
    input  oaht_pkg::t_in_item  i_data,
    output logic                o_valid,
    input  wire                 i_stall,
    output oaht_pkg::t_out_item o_data
);
    localparam int AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int PW = AW + 1;

    logic [KEY_BITS-1:0]   m_key [SLOTS];
    logic [VALUE_BITS-1:0] m_val [SLOTS];
    logic [1:0]            m_flag [SLOTS];

    oaht_pkg::t_state r_state, n_state;
    oaht_pkg::t_in_item r_item;
    logic [AW-1:0] r_idx, n_idx;
    logic [AW-1:0] r_step, n_step;
    logic [PW-1:0] r_probe, n_probe;
    logic [KEY_BITS-1:0]   r_rkey;
    logic [VALUE_BITS-1:0] r_rval;
    logic [1:0]            r_rflag;
    logic [10:0] r_count, n_count;
    logic        r_ovalid, n_ovalid;
    oaht_pkg::t_out_item r_out, n_out;

    logic          fl_we, kv_we, vv_we;
    logic [1:0]    fl_wd;
    logic [AW-1:0] wa;
    logic          used, live, match;

    assign used  = r_rflag[0];
    assign live  = r_rflag[0] && !r_rflag[1];
    assign match = live && (r_rkey == KEY_BITS'(r_item.key));
    assign o_valid = r_ovalid;
    assign o_data  = r_out;

    always_comb begin
        n_state  = r_state;
        n_idx    = r_idx;
        n_step   = r_step;
        n_probe  = r_probe;
        n_count  = r_count;
        n_ovalid = r_ovalid;
        n_out    = r_out;
        o_take   = 1'b0;
        fl_we    = 1'b0;
        kv_we    = 1'b0;
        vv_we    = 1'b0;
        fl_wd    = 2'b00;
        wa       = r_idx;
        if (r_ovalid && !i_stall) n_ovalid = 1'b0;
        unique case (r_state)
            oaht_pkg::ST_CLEAR: begin
                fl_we = 1'b1;
                n_idx = r_idx + 1'b1;
                if (r_idx == AW'(SLOTS - 1)) begin
                    n_state = oaht_pkg::ST_IDLE;
                end
            end
            oaht_pkg::ST_IDLE: begin
                if (i_valid && (!r_ovalid || !i_stall)) begin
                    o_take  = 1'b1;
                    n_idx   = AW'(i_data.key);
                    n_step  = AW'(1);
                    n_probe = '0;
                    n_state = oaht_pkg::ST_READ;
                end
            end
            oaht_pkg::ST_READ: n_state = oaht_pkg::ST_WAIT;
            oaht_pkg::ST_WAIT: n_state = oaht_pkg::ST_CHECK;
            oaht_pkg::ST_CHECK: begin
                n_out.ok         = 1'b0;
                n_out.read_value = '0;
                n_out.live_count = r_count;
                n_state          = oaht_pkg::ST_DONE;
                priority if (r_item.mode == oaht_pkg::MODE_NOP) begin
                end else if (!used && r_item.mode == oaht_pkg::MODE_PUT) begin
                    fl_we = 1'b1;
                    fl_wd = 2'b01;
                    kv_we = 1'b1;
                    vv_we = 1'b1;
                    n_count = r_count + 11'd1;
                    n_out.ok = 1'b1;
                    n_out.live_count = r_count + 11'd1;
                end else if (!used) begin
                end else if (match) begin
                    n_out.ok = 1'b1;
                    if (r_item.mode == oaht_pkg::MODE_GET) begin
                        n_out.read_value = 32'(r_rval);
                    end else if (r_item.mode == oaht_pkg::MODE_PUT) begin
                        vv_we = 1'b1;
                    end else begin
                        fl_we = 1'b1;
                        fl_wd = 2'b11;
                        if (r_count != 11'd0) n_count = r_count - 11'd1;
                        n_out.live_count = n_count;
                    end
                end else if (r_probe != PW'(SLOTS - 1)) begin
                    n_probe = r_probe + 1'b1;
                    n_idx   = r_idx + r_step;
                    n_step  = r_step + AW'(2);
                    n_state = oaht_pkg::ST_READ;
                end
            end
            oaht_pkg::ST_DONE: begin
                n_ovalid = 1'b1;
                n_state  = oaht_pkg::ST_IDLE;
            end
            default: n_state = oaht_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= oaht_pkg::ST_CLEAR;
            r_idx    <= '0;
            r_count  <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_idx    <= n_idx;
            r_count  <= n_count;
            r_ovalid <= n_ovalid;
        end
        r_step  <= n_step;
        r_probe <= n_probe;
        r_out   <= n_out;
        if (o_take) r_item <= i_data;
    end

    always_ff @(posedge i_clk) begin
        if (fl_we) m_flag[wa] <= fl_wd;
        if (kv_we) m_key[wa]  <= KEY_BITS'(r_item.key);
        if (vv_we) m_val[wa]  <= VALUE_BITS'(r_item.value);
        r_rflag <= m_flag[r_idx];
        r_rkey  <= m_key[r_idx];
        r_rval  <= m_val[r_idx];
    end
endmodule
`default_nettype wire

>>> rtl/open_address_hash_table.sv
`timescale 1ns / 1ps
`default_nettype none
// Open-addressed key/value table with quadratic probing.
// Input channel i_valid/o_stall carries an item with mode, key and value;
// mode 0 looks a key up, 1 inserts or updates, 2 removes, 3 does nothing.
// Output channel o_valid/i_stall carries ok, read_value and live_count.
// A two-entry queue in front accepts items while the probe engine works.
// Each probe steps through the states READ, WAIT and CHECK (address, registered
// read, compare); an item takes up to SLOTS probes, and the engine takes the
// next item only after it has finished the last one.
// After reset the engine clears every slot flag and takes no item while it
// does so; the queue still fills.
// One result is produced per item, in order. While i_stall is high and a result
// waits, the result register holds and the engine stops before the next item.
module open_address_hash_table #(
    parameter int SLOTS      = 1024,
    parameter int KEY_BITS   = 32,
    parameter int VALUE_BITS = 32
) (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_valid,
    output logic                 o_stall,
    input  oaht_pkg::t_in_item   i_data,
    output logic                 o_valid,
    input  wire                  i_stall,
    output oaht_pkg::t_out_item  o_data
);
    oaht_pkg::t_in_item q_data;
    logic q_valid, q_take;

    oaht_front u_front (
        .i_clk, .i_rst_n, .i_valid, .o_stall, .i_data,
        .o_valid(q_valid), .i_take(q_take), .o_data(q_data)
    );

    oaht_back #(.SLOTS(SLOTS), .KEY_BITS(KEY_BITS), .VALUE_BITS(VALUE_BITS)) u_back (
        .i_clk, .i_rst_n, .i_valid(q_valid), .o_take(q_take), .i_data(q_data),
        .o_valid, .i_stall, .o_data
    );
endmodule
`default_nettype wire

>>> rtl/oaht_checker.sv
`timescale 1ns / 1ps
`default_nettype none
`include "open_address_hash_table_assert.svh"
module oaht_checker (
    input wire                  i_clk,
    input wire                  i_rst_n,
    input wire                  o_valid,
    input wire                  i_stall,
    input oaht_pkg::t_out_item  o_data
);
    `OAHT_ASSERT_NEXT(a_hold, i_clk, i_rst_n, o_valid && i_stall, o_valid && $stable(o_data))
    `OAHT_ASSERT_IMP(a_rd_zero, i_clk, i_rst_n, o_valid && !o_data.ok, o_data.read_value == 32'd0)
    `OAHT_ASSERT_IMP(a_cnt_max, i_clk, i_rst_n, o_valid, o_data.live_count <= 11'd1024)
endmodule
bind open_address_hash_table oaht_checker u_chk (
    .i_clk, .i_rst_n, .o_valid, .i_stall, .o_data
);
`default_nettype wire

>>> tb/tb_open_address_hash_table.sv
`timescale 1ns / 1ps
module tb_open_address_hash_table;

    localparam int SLOTS = 1024;
    localparam logic [31:0] MASK = 32'(SLOTS - 1);

    // Tracks the table contents and the results that are still owed.
    class table_scoreboard;
        logic [31:0] keys[SLOTS];
        logic [31:0] values[SLOTS];
        bit used[SLOTS];
        bit tomb[SLOTS];
        int unsigned live;
        oaht_pkg::t_out_item pending[$];
        int errors;
        int lookups_hit;
        int full_inserts;

        function void note_item(oaht_pkg::t_in_item it);
            oaht_pkg::t_out_item r;
            logic [31:0] idx;
            bit is_match;
            r = '0;
            for (int p = 0; p < SLOTS; p++) begin
                idx = ((it.key & MASK) + 32'(p * p)) & MASK;
                is_match = used[idx] && !tomb[idx] && keys[idx] == it.key;
                if (it.mode == oaht_pkg::MODE_GET) begin
                    if (!used[idx]) break;
                    if (is_match) begin
                        r.ok = 1'b1;
                        r.read_value = values[idx];
                        lookups_hit++;
                        break;
                    end
                end else if (it.mode == oaht_pkg::MODE_PUT) begin
                    if (!used[idx]) begin
                        used[idx] = 1'b1;
                        tomb[idx] = 1'b0;
                        keys[idx] = it.key;
                        values[idx] = it.value;
                        live++;
                        r.ok = 1'b1;
                        break;
                    end
                    if (is_match) begin
                        values[idx] = it.value;
                        r.ok = 1'b1;
                        break;
                    end
                    if (p == SLOTS - 1) full_inserts++;
                end else if (it.mode == oaht_pkg::MODE_DEL) begin
                    if (!used[idx]) break;
                    if (is_match) begin
                        tomb[idx] = 1'b1;
                        if (live > 0) live--;
                        r.ok = 1'b1;
                        break;
                    end
                end else begin
                    break;
                end
            end
            r.live_count = live[10:0];
            pending.push_back(r);
        endfunction

        function void check_result(oaht_pkg::t_out_item got);
            oaht_pkg::t_out_item want;
            if (pending.size() == 0) begin
                $display("%0t: unexpected result %h", $time, got);
                errors++;
                return;
            end
            want = pending.pop_front();
            if (got.ok !== want.ok)
                $display("%0t: ok expected %0d actual %0d", $time, want.ok, got.ok);
            if (got.read_value !== want.read_value)
                $display("%0t: read_value expected %h actual %h", $time,
                         want.read_value, got.read_value);
            if (got.live_count !== want.live_count)
                $display("%0t: live_count expected %0d actual %0d", $time,
                         want.live_count, got.live_count);
            if (got !== want) errors++;
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_valid = 1'b0;
    logic i_stall = 1'b0;
    oaht_pkg::t_in_item i_data = '0;
    logic o_stall;
    logic o_valid;
    oaht_pkg::t_out_item o_data;

    table_scoreboard sb = new();
    bit idle_on = 1'b1;
    int sent = 0;
    logic [31:0] key_pool[16];

    always #1 i_clk = ~i_clk;

    open_address_hash_table i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_stall(o_stall),
        .i_data(i_data), .o_valid(o_valid), .i_stall(i_stall), .o_data(o_data)
    );

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) sb.check_result(o_data);
    end

    // Receiver stalls in random bursts.
    initial begin
        int n;
        forever begin
            @(posedge i_clk);
            if (idle_on && $urandom_range(0, 5) == 0) begin
                n = $urandom_range(1, 10);
                i_stall <= 1'b1;
                repeat (n) @(posedge i_clk);
            end
            i_stall <= 1'b0;
        end
    end

    task automatic send_item(input logic [1:0] m, input logic [31:0] k,
                             input logic [31:0] v);
        oaht_pkg::t_in_item it;
        it.mode = m;
        it.key = k;
        it.value = v;
        if (idle_on && $urandom_range(0, 4) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_data <= it;
        do @(posedge i_clk); while (o_stall);
        sb.note_item(it);
        sent++;
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge i_clk);
    endtask

    function automatic logic [31:0] rand_key();
        case ($urandom_range(0, 3))
            0: return key_pool[$urandom_range(0, 15)];
            1: return key_pool[$urandom_range(0, 15)] + SLOTS * $urandom_range(1, 3);
            2: return $urandom_range(0, 63);
            default: return $urandom();
        endcase
    endfunction

    initial begin
        logic [1:0] m;
        logic [31:0] k;
        for (int i = 0; i < 16; i++) key_pool[i] = $urandom();
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: extremes, collisions on one home slot, tombstones, unused mode.
        send_item(oaht_pkg::MODE_GET, 32'h0, 32'h0);
        send_item(oaht_pkg::MODE_DEL, 32'h0, 32'h0);
        send_item(oaht_pkg::MODE_PUT, 32'h0, 32'hFFFF_FFFF);
        send_item(oaht_pkg::MODE_PUT, 32'hFFFF_FFFF, 32'h0);
        send_item(oaht_pkg::MODE_GET, 32'h0, 32'h1234);
        send_item(oaht_pkg::MODE_GET, 32'hFFFF_FFFF, 32'h0);
        send_item(oaht_pkg::MODE_PUT, 32'h0, 32'hA5A5_5A5A);
        send_item(oaht_pkg::MODE_PUT, 32'h400, 32'h1);
        send_item(oaht_pkg::MODE_PUT, 32'h800, 32'h2);
        send_item(oaht_pkg::MODE_PUT, 32'hC00, 32'h3);
        send_item(oaht_pkg::MODE_DEL, 32'h400, 32'h0);
        send_item(oaht_pkg::MODE_GET, 32'h800, 32'h0);
        send_item(oaht_pkg::MODE_GET, 32'h400, 32'h0);
        send_item(oaht_pkg::MODE_DEL, 32'h400, 32'h0);
        send_item(oaht_pkg::MODE_PUT, 32'h400, 32'h7);
        send_item(oaht_pkg::MODE_GET, 32'h400, 32'h0);
        send_item(oaht_pkg::MODE_NOP, 32'h0, 32'hFFFF_FFFF);
        send_item(oaht_pkg::MODE_GET, 32'hC00, 32'h0);
        send_item(oaht_pkg::MODE_DEL, 32'hFFFF_FFFF, 32'h0);
        drain();

        for (int i = 0; i < 380; i++) begin
            if (i > 320) idle_on = 1'b0;
            case ($urandom_range(0, 9))
                0, 1, 2, 3: m = oaht_pkg::MODE_PUT;
                4, 5, 6: m = oaht_pkg::MODE_GET;
                7, 8: m = oaht_pkg::MODE_DEL;
                default: m = oaht_pkg::MODE_NOP;
            endcase
            k = rand_key();
            send_item(m, k, $urandom());
            if (i == 200) drain();
        end
        drain();
        repeat (200) @(posedge i_clk);
        $display("Sent %0d items: lookups, inserts, removes and unused mode,", sent);
        $display("with %0d lookup hits and colliding keys on shared home slots.",
                 sb.lookups_hit);
        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("PASS open_address_hash_table");
        end else begin
            $display("FAIL open_address_hash_table");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("FAIL open_address_hash_table");
        $finish;
    end
endmodule
